// ----- rtl/core/task_ready_and_wakeup_list_manager_macros.svh -----
// assertion helpers for the task list manager
`ifndef TASK_READY_AND_WAKEUP_LIST_MANAGER_MACROS_SVH
`define TASK_READY_AND_WAKEUP_LIST_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define TRWL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trwl check failed");
`define TRWL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trwl check failed");
`else
`define TRWL_ASSERT_IMPL(lbl, ante, cons)
`define TRWL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/trwl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package trwl_pkg;

  localparam int unsigned NUM_TASKS_DEF     = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 8;
  localparam int unsigned TICK_BITS_DEF     = 32;

  localparam int unsigned ACT_W     = 4;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned PRIO_IN_W = 8;
  localparam int unsigned TICK_IN_W = 32;
  localparam int unsigned REASON_W  = 2;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned STATE_W   = 3;

  typedef enum logic [STATE_W-1:0] {
    ST_UNUSED, ST_READY, ST_RUNNING, ST_BLOCKED, ST_SUSPENDED, ST_TERMINATED
  } task_state_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE, ACT_READY, ACT_BLOCK, ACT_RUN, ACT_SUSPEND, ACT_TERMINATE,
    ACT_SET_PRIO, ACT_SET_TICK, ACT_WAKE_INS, ACT_WAKE_REM, ACT_TAIL, ACT_QUERY
  } action_e;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE, RSN_DELAY, RSN_EVENT, RSN_WAIT
  } reason_e;

  typedef enum logic [2:0] {
    K_HOLD, K_ZERO, K_INC, K_PREV, K_NEXT
  } k_op_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_DECODE, CS_RSCAN, CS_WSCAN, CS_PPREV, CS_PNEXT,
    CS_TPREV, CS_TNEXT, CS_QUERY, CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic        load;
    logic        ld_key;
    logic        rd_s;
    logic        lst;
    k_op_e       k_op;
    logic        rrem;
    logic        rins;
    logic        wrem;
    logic        wins;
    logic        wr_st;
    task_state_e st_val;
    logic        wr_rsn;
    logic        rsn_in;
    logic        wr_prio;
    logic        wr_tick;
    logic        create;
    logic        set_ok;
    logic        set_nxt;
    logic        done;
  } trwl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             slot_ok;
    logic             free_found;
    task_state_e      st;
    logic             timed;
    logic             inw;
    logic             pos_first;
    logic             pos_last;
    logic             k_end;
    logic             p_eq;
    logic             t_eq;
    logic             r_key_gt;
    logic             r_in_le;
    logic             r_in_ge;
    logic             w_key_bf;
    logic             w_in_nbf;
    logic             w_rd_nbf;
  } trwl_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/task_ready_and_wakeup_list_manager.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                    payload
// command   in         in_valid_i / in_stall_o      action, slot, new_priority, wake_tick,
//                                                   wait_reason
// result    out        out_valid_o / out_stall_i    ok, created_slot, ready_head, ready_nonempty,
//                                                   ready_count, wakeup_head, wakeup_nonempty,
//                                                   next_wakeup, next_valid, slot_state
//
// one command at a time: accept, decode, then for a list insert a walk of one position a cycle
// through the single table read port; a reorder first makes two neighbor checks, then, if the
// entry no longer fits, a walk of the list
// reset empties the slot table and both lists at once, no clearing pass
// the result register holds until taken; the next item is accepted meanwhile
// but its result waits in the finish state until the register is free
module task_ready_and_wakeup_list_manager #(
  parameter int unsigned NUM_TASKS     = trwl_pkg::NUM_TASKS_DEF,
  parameter int unsigned PRIORITY_BITS = trwl_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned TICK_BITS     = trwl_pkg::TICK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [trwl_pkg::ACT_W-1:0]      action_i,
  input  logic [trwl_pkg::SLOT_W-1:0]     slot_i,
  input  logic [trwl_pkg::PRIO_IN_W-1:0]  new_priority_i,
  input  logic [trwl_pkg::TICK_IN_W-1:0]  wake_tick_i,
  input  logic [trwl_pkg::REASON_W-1:0]   wait_reason_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ok_o,
  output logic [trwl_pkg::SLOT_W-1:0]     created_slot_o,
  output logic [trwl_pkg::SLOT_W-1:0]     ready_head_o,
  output logic                            ready_nonempty_o,
  output logic [trwl_pkg::COUNT_W-1:0]    ready_count_o,
  output logic [trwl_pkg::SLOT_W-1:0]     wakeup_head_o,
  output logic                            wakeup_nonempty_o,
  output logic [trwl_pkg::SLOT_W-1:0]     next_wakeup_o,
  output logic                            next_valid_o,
  output logic [trwl_pkg::STATE_W-1:0]    slot_state_o
);

  trwl_pkg::trwl_cmd_t  cmd;
  trwl_pkg::trwl_stat_t stat;

  trwl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  trwl_datapath #(
    .NUM_TASKS     (NUM_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TICK_BITS     (TICK_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (action_i),
    .slot_i            (slot_i),
    .new_priority_i    (new_priority_i),
    .wake_tick_i       (wake_tick_i),
    .wait_reason_i     (wait_reason_i),
    .ok_o              (ok_o),
    .created_slot_o    (created_slot_o),
    .ready_head_o      (ready_head_o),
    .ready_nonempty_o  (ready_nonempty_o),
    .ready_count_o     (ready_count_o),
    .wakeup_head_o     (wakeup_head_o),
    .wakeup_nonempty_o (wakeup_nonempty_o),
    .next_wakeup_o     (next_wakeup_o),
    .next_valid_o      (next_valid_o),
    .slot_state_o      (slot_state_o)
  );

`include "task_ready_and_wakeup_list_manager_macros.svh"

  `TRWL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `TRWL_ASSERT_IMPL(a_one_ready_op, cmd.rins, !cmd.rrem)
  `TRWL_ASSERT_IMPL(a_count_nonempty, out_valid_o && (ready_count_o != '0), ready_nonempty_o)
  `TRWL_ASSERT_IMPL(a_next_zero, out_valid_o && !next_valid_o, next_wakeup_o == '0)

endmodule
`default_nettype wire

// ----- rtl/core/trwl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trwl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  trwl_pkg::trwl_stat_t   stat_i,
  output trwl_pkg::trwl_cmd_t    cmd_o
);

  trwl_pkg::ctrl_state_e state_q, state_d;
  logic fit_q, fit_d;
  logic out_valid_q, out_valid_d;
  logic bt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trwl_pkg::CS_IDLE;
      fit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fit_q       <= fit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != trwl_pkg::CS_IDLE);
  assign out_valid_o = out_valid_q;
  assign bt = (stat_i.st == trwl_pkg::ST_BLOCKED) && stat_i.timed;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    fit_d       = fit_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      trwl_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = trwl_pkg::CS_DECODE;
        end
      end
      trwl_pkg::CS_DECODE: begin
        cmd_o.rd_s   = 1'b1;
        cmd_o.ld_key = 1'b1;
        cmd_o.lst    = (stat_i.act == trwl_pkg::ACT_SET_TICK) ||
                       (stat_i.act == trwl_pkg::ACT_QUERY);
        state_d      = trwl_pkg::CS_FINISH;
        if (stat_i.act == trwl_pkg::ACT_CREATE) begin
          if (stat_i.free_found) begin
            cmd_o.create = 1'b1;
            cmd_o.set_ok = 1'b1;
            cmd_o.k_op   = trwl_pkg::K_ZERO;
            state_d      = trwl_pkg::CS_RSCAN;
          end
        end else if (stat_i.slot_ok) begin
          unique case (stat_i.act)
            trwl_pkg::ACT_READY: begin
              if (stat_i.st == trwl_pkg::ST_READY) begin
                cmd_o.set_ok = 1'b1;
              end else if (!(bt && !stat_i.inw)) begin
                cmd_o.wrem   = bt;
                cmd_o.wr_st  = 1'b1;
                cmd_o.st_val = trwl_pkg::ST_READY;
                cmd_o.wr_rsn = 1'b1;
                cmd_o.k_op   = trwl_pkg::K_ZERO;
                cmd_o.set_ok = 1'b1;
                state_d      = trwl_pkg::CS_RSCAN;
              end
            end
            trwl_pkg::ACT_BLOCK, trwl_pkg::ACT_RUN, trwl_pkg::ACT_TERMINATE: begin
              cmd_o.set_ok = 1'b1;
              priority if (stat_i.act == trwl_pkg::ACT_BLOCK) begin
                cmd_o.st_val = trwl_pkg::ST_BLOCKED;
                cmd_o.wr_rsn = 1'b1;
                cmd_o.rsn_in = 1'b1;
              end else if (stat_i.act == trwl_pkg::ACT_RUN) begin
                cmd_o.st_val = trwl_pkg::ST_RUNNING;
              end else begin
                cmd_o.st_val = trwl_pkg::ST_TERMINATED;
              end
              if (stat_i.st != cmd_o.st_val) begin
                cmd_o.wr_st = 1'b1;
                cmd_o.rrem  = (stat_i.st == trwl_pkg::ST_READY);
              end
            end
            trwl_pkg::ACT_SUSPEND: begin
              if (stat_i.st == trwl_pkg::ST_SUSPENDED) begin
                cmd_o.set_ok = 1'b1;
              end else if (!(bt && !stat_i.inw)) begin
                cmd_o.wrem   = bt;
                cmd_o.rrem   = (stat_i.st == trwl_pkg::ST_READY);
                cmd_o.wr_st  = 1'b1;
                cmd_o.st_val = trwl_pkg::ST_SUSPENDED;
                cmd_o.wr_rsn = 1'b1;
                cmd_o.set_ok = 1'b1;
              end
            end
            trwl_pkg::ACT_SET_PRIO: begin
              if (stat_i.p_eq) begin
                cmd_o.set_ok = 1'b1;
              end else if (stat_i.st != trwl_pkg::ST_READY) begin
                cmd_o.wr_prio = 1'b1;
                cmd_o.set_ok  = 1'b1;
              end else begin
                cmd_o.k_op = trwl_pkg::K_PREV;
                state_d    = trwl_pkg::CS_PPREV;
              end
            end
            trwl_pkg::ACT_SET_TICK: begin
              if (stat_i.t_eq) begin
                cmd_o.set_ok = 1'b1;
              end else if (!(bt && stat_i.inw)) begin
                cmd_o.wr_tick = 1'b1;
                cmd_o.set_ok  = 1'b1;
              end else begin
                cmd_o.k_op = trwl_pkg::K_PREV;
                state_d    = trwl_pkg::CS_TPREV;
              end
            end
            trwl_pkg::ACT_WAKE_INS: begin
              if (bt && !stat_i.inw) begin
                cmd_o.k_op   = trwl_pkg::K_ZERO;
                cmd_o.set_ok = 1'b1;
                state_d      = trwl_pkg::CS_WSCAN;
              end
            end
            trwl_pkg::ACT_WAKE_REM: begin
              if (bt && stat_i.inw) begin
                cmd_o.wrem   = 1'b1;
                cmd_o.set_ok = 1'b1;
              end
            end
            trwl_pkg::ACT_TAIL: begin
              if (stat_i.st == trwl_pkg::ST_RUNNING) begin
                cmd_o.wr_st  = 1'b1;
                cmd_o.st_val = trwl_pkg::ST_READY;
                cmd_o.wr_rsn = 1'b1;
                cmd_o.k_op   = trwl_pkg::K_ZERO;
                cmd_o.set_ok = 1'b1;
                state_d      = trwl_pkg::CS_RSCAN;
              end else if (stat_i.st == trwl_pkg::ST_READY) begin
                cmd_o.rrem   = 1'b1;
                cmd_o.k_op   = trwl_pkg::K_ZERO;
                cmd_o.set_ok = 1'b1;
                state_d      = trwl_pkg::CS_RSCAN;
              end
            end
            trwl_pkg::ACT_QUERY: begin
              cmd_o.set_ok = 1'b1;
              if (stat_i.inw && !stat_i.pos_last) begin
                cmd_o.k_op = trwl_pkg::K_NEXT;
                state_d    = trwl_pkg::CS_QUERY;
              end
            end
            default: ;
          endcase
        end
      end
      trwl_pkg::CS_RSCAN: begin
        if (stat_i.k_end || stat_i.r_key_gt) begin
          cmd_o.rins = 1'b1;
          state_d    = trwl_pkg::CS_FINISH;
        end else begin
          cmd_o.k_op = trwl_pkg::K_INC;
        end
      end
      trwl_pkg::CS_WSCAN: begin
        cmd_o.lst = 1'b1;
        if (stat_i.k_end || stat_i.w_key_bf) begin
          cmd_o.wins = 1'b1;
          state_d    = trwl_pkg::CS_FINISH;
        end else begin
          cmd_o.k_op = trwl_pkg::K_INC;
        end
      end
      trwl_pkg::CS_PPREV: begin
        fit_d      = stat_i.pos_first || stat_i.r_in_le;
        cmd_o.k_op = trwl_pkg::K_NEXT;
        state_d    = trwl_pkg::CS_PNEXT;
      end
      trwl_pkg::CS_PNEXT: begin
        cmd_o.wr_prio = 1'b1;
        cmd_o.set_ok  = 1'b1;
        if (fit_q && (stat_i.pos_last || stat_i.r_in_ge)) begin
          state_d = trwl_pkg::CS_FINISH;
        end else begin
          cmd_o.rrem = 1'b1;
          cmd_o.k_op = trwl_pkg::K_ZERO;
          state_d    = trwl_pkg::CS_RSCAN;
        end
      end
      trwl_pkg::CS_TPREV: begin
        cmd_o.lst  = 1'b1;
        fit_d      = stat_i.pos_first || stat_i.w_in_nbf;
        cmd_o.k_op = trwl_pkg::K_NEXT;
        state_d    = trwl_pkg::CS_TNEXT;
      end
      trwl_pkg::CS_TNEXT: begin
        cmd_o.lst     = 1'b1;
        cmd_o.wr_tick = 1'b1;
        cmd_o.set_ok  = 1'b1;
        if (fit_q && (stat_i.pos_last || stat_i.w_rd_nbf)) begin
          state_d = trwl_pkg::CS_FINISH;
        end else begin
          cmd_o.wrem = 1'b1;
          cmd_o.k_op = trwl_pkg::K_ZERO;
          state_d    = trwl_pkg::CS_WSCAN;
        end
      end
      trwl_pkg::CS_QUERY: begin
        cmd_o.lst     = 1'b1;
        cmd_o.set_nxt = 1'b1;
        state_d       = trwl_pkg::CS_FINISH;
      end
      trwl_pkg::CS_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.done  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = trwl_pkg::CS_IDLE;
        end
      end
      default: state_d = trwl_pkg::CS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/trwl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module trwl_datapath #(
  parameter int unsigned NUM_TASKS     = trwl_pkg::NUM_TASKS_DEF,
  parameter int unsigned PRIORITY_BITS = trwl_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned TICK_BITS     = trwl_pkg::TICK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  trwl_pkg::trwl_cmd_t             cmd_i,
  output trwl_pkg::trwl_stat_t            stat_o,
  input  logic [trwl_pkg::ACT_W-1:0]      action_i,
  input  logic [trwl_pkg::SLOT_W-1:0]     slot_i,
  input  logic [trwl_pkg::PRIO_IN_W-1:0]  new_priority_i,
  input  logic [trwl_pkg::TICK_IN_W-1:0]  wake_tick_i,
  input  logic [trwl_pkg::REASON_W-1:0]   wait_reason_i,
  output logic                            ok_o,
  output logic [trwl_pkg::SLOT_W-1:0]     created_slot_o,
  output logic [trwl_pkg::SLOT_W-1:0]     ready_head_o,
  output logic                            ready_nonempty_o,
  output logic [trwl_pkg::COUNT_W-1:0]    ready_count_o,
  output logic [trwl_pkg::SLOT_W-1:0]     wakeup_head_o,
  output logic                            wakeup_nonempty_o,
  output logic [trwl_pkg::SLOT_W-1:0]     next_wakeup_o,
  output logic                            next_valid_o,
  output logic [trwl_pkg::STATE_W-1:0]    slot_state_o
);

  localparam int unsigned IW = $clog2(NUM_TASKS);
  localparam int unsigned KW = $clog2(NUM_TASKS + 1);

  trwl_pkg::task_state_e         st_q   [NUM_TASKS];
  logic [trwl_pkg::REASON_W-1:0] rsn_q  [NUM_TASKS];
  logic [PRIORITY_BITS-1:0]      prio_q [NUM_TASKS];
  logic [TICK_BITS-1:0]          tick_q [NUM_TASKS];
  logic                          rmem_q [NUM_TASKS];
  logic                          wmem_q [NUM_TASKS];
  logic [IW-1:0]                 rpos_q [NUM_TASKS];
  logic [IW-1:0]                 wpos_q [NUM_TASKS];
  logic [KW-1:0]                 rlen_q, wlen_q, k_q;

  logic [IW-1:0]                 s_q, nxt_q;
  logic [trwl_pkg::ACT_W-1:0]    act_q;
  logic [PRIORITY_BITS-1:0]      pin_q, pkey_q;
  logic [TICK_BITS-1:0]          tin_q, tkey_q;
  logic [trwl_pkg::REASON_W-1:0] rin_q;
  logic                          slot_ok_q, ok_q, nv_q;

  logic [31:0]              prio_ext, s_ext, rh_ext, wh_ext, nx_ext, rl_ext;
  logic                     free_found;
  logic [IW-1:0]            free_idx, at_r, at_w, r_head, w_head, rd_idx, pos_s;
  logic [KW-1:0]            len_s;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [TICK_BITS-1:0]     rd_tick;
  logic                     have_slot;

  function automatic logic before_f(input logic [TICK_BITS-1:0] a,
                                    input logic [TICK_BITS-1:0] b);
    logic [TICK_BITS-1:0] d;
    d = a - b;
    return d[TICK_BITS-1];
  endfunction

  assign prio_ext = 32'(new_priority_i);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NUM_TASKS - 1; j >= 0; j--) begin
      if (st_q[j] == trwl_pkg::ST_UNUSED) begin
        free_found = 1'b1;
        free_idx   = IW'(j);
      end
    end
  end

  // slot sitting at list position k, and the list heads
  always_comb begin
    at_r   = '0;
    at_w   = '0;
    r_head = '0;
    w_head = '0;
    for (int j = 0; j < NUM_TASKS; j++) begin
      if (rmem_q[j] && (KW'(rpos_q[j]) == k_q)) at_r = IW'(j);
      if (wmem_q[j] && (KW'(wpos_q[j]) == k_q)) at_w = IW'(j);
      if (rmem_q[j] && (rpos_q[j] == '0)) r_head = IW'(j);
      if (wmem_q[j] && (wpos_q[j] == '0)) w_head = IW'(j);
    end
  end

  assign rd_idx  = cmd_i.rd_s ? s_q : (cmd_i.lst ? at_w : at_r);
  assign rd_prio = prio_q[rd_idx];
  assign rd_tick = tick_q[rd_idx];
  assign pos_s   = cmd_i.lst ? wpos_q[s_q] : rpos_q[s_q];
  assign len_s   = cmd_i.lst ? wlen_q : rlen_q;

  always_comb begin
    stat_o.act        = act_q;
    stat_o.slot_ok    = slot_ok_q;
    stat_o.free_found = free_found;
    stat_o.st         = st_q[s_q];
    stat_o.timed      = (rsn_q[s_q] == trwl_pkg::RSN_DELAY) ||
                        (rsn_q[s_q] == trwl_pkg::RSN_EVENT);
    stat_o.inw        = wmem_q[s_q];
    stat_o.pos_first  = (pos_s == '0);
    stat_o.pos_last   = ((KW'(pos_s) + KW'(1)) >= len_s);
    stat_o.k_end      = (k_q == len_s);
    stat_o.p_eq       = (rd_prio == pin_q);
    stat_o.t_eq       = (rd_tick == tin_q);
    stat_o.r_key_gt   = (pkey_q > rd_prio);
    stat_o.r_in_le    = (rd_prio >= pin_q);
    stat_o.r_in_ge    = (pin_q >= rd_prio);
    stat_o.w_key_bf   = before_f(tkey_q, rd_tick);
    stat_o.w_in_nbf   = !before_f(tin_q, rd_tick);
    stat_o.w_rd_nbf   = !before_f(rd_tick, tin_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_TASKS; j++) begin
        st_q[j]   <= trwl_pkg::ST_UNUSED;
        rsn_q[j]  <= trwl_pkg::RSN_NONE;
        tick_q[j] <= '0;
        rmem_q[j] <= 1'b0;
        wmem_q[j] <= 1'b0;
      end
      rlen_q <= '0;
      wlen_q <= '0;
    end else begin
      if (cmd_i.create) begin
        st_q[free_idx]   <= trwl_pkg::ST_READY;
        rsn_q[free_idx]  <= trwl_pkg::RSN_NONE;
        tick_q[free_idx] <= '0;
        wmem_q[free_idx] <= 1'b0;
      end
      if (cmd_i.wr_st) st_q[s_q] <= cmd_i.st_val;
      if (cmd_i.wr_rsn) rsn_q[s_q] <= cmd_i.rsn_in ? rin_q : trwl_pkg::RSN_NONE;
      if (cmd_i.wr_tick) tick_q[s_q] <= tin_q;
      if (cmd_i.rrem) begin
        rmem_q[s_q] <= 1'b0;
        rlen_q      <= rlen_q - KW'(1);
      end
      if (cmd_i.rins) begin
        rmem_q[s_q] <= 1'b1;
        rlen_q      <= rlen_q + KW'(1);
      end
      if (cmd_i.wrem) begin
        wmem_q[s_q] <= 1'b0;
        wlen_q      <= wlen_q - KW'(1);
      end
      if (cmd_i.wins) begin
        wmem_q[s_q] <= 1'b1;
        wlen_q      <= wlen_q + KW'(1);
      end
    end
  end

  // list positions shift around the removed or inserted entry
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NUM_TASKS; j++) begin
      if (cmd_i.rrem && rmem_q[j] && (rpos_q[j] > rpos_q[s_q])) rpos_q[j] <= rpos_q[j] - IW'(1);
      if (cmd_i.rins && rmem_q[j] && (KW'(rpos_q[j]) >= k_q)) rpos_q[j] <= rpos_q[j] + IW'(1);
      if (cmd_i.wrem && wmem_q[j] && (wpos_q[j] > wpos_q[s_q])) wpos_q[j] <= wpos_q[j] - IW'(1);
      if (cmd_i.wins && wmem_q[j] && (KW'(wpos_q[j]) >= k_q)) wpos_q[j] <= wpos_q[j] + IW'(1);
    end
    if (cmd_i.rins) rpos_q[s_q] <= IW'(k_q);
    if (cmd_i.wins) wpos_q[s_q] <= IW'(k_q);
    if (cmd_i.create) prio_q[free_idx] <= pin_q;
    if (cmd_i.wr_prio) prio_q[s_q] <= pin_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      s_q       <= IW'(slot_i);
      pin_q     <= prio_ext[PRIORITY_BITS-1:0];
      tin_q     <= wake_tick_i[TICK_BITS-1:0];
      rin_q     <= wait_reason_i;
      slot_ok_q <= (32'(slot_i) < 32'(NUM_TASKS));
      ok_q      <= 1'b0;
      nv_q      <= 1'b0;
      nxt_q     <= '0;
    end
    if (cmd_i.create) s_q <= free_idx;
    if (cmd_i.set_ok) ok_q <= 1'b1;
    if (cmd_i.set_nxt) begin
      nxt_q <= at_w;
      nv_q  <= 1'b1;
    end
    if (cmd_i.create || cmd_i.wr_prio) pkey_q <= pin_q;
    else if (cmd_i.ld_key) pkey_q <= rd_prio;
    if (cmd_i.wr_tick) tkey_q <= tin_q;
    else if (cmd_i.ld_key) tkey_q <= rd_tick;
    unique case (cmd_i.k_op)
      trwl_pkg::K_ZERO: k_q <= '0;
      trwl_pkg::K_INC:  k_q <= k_q + KW'(1);
      trwl_pkg::K_PREV: k_q <= KW'(pos_s) - KW'(1);
      trwl_pkg::K_NEXT: k_q <= KW'(pos_s) + KW'(1);
      default:          k_q <= k_q;
    endcase
  end

  assign s_ext  = 32'(s_q);
  assign rh_ext = 32'(r_head);
  assign wh_ext = 32'(w_head);
  assign nx_ext = 32'(nxt_q);
  assign rl_ext = 32'(rlen_q);
  assign have_slot = (act_q == trwl_pkg::ACT_CREATE) ? ok_q :
                     (slot_ok_q && (act_q <= trwl_pkg::ACT_QUERY));

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      ok_o              <= ok_q;
      created_slot_o    <= ((act_q == trwl_pkg::ACT_CREATE) && ok_q) ?
                           s_ext[trwl_pkg::SLOT_W-1:0] : '0;
      ready_head_o      <= (rlen_q != '0) ? rh_ext[trwl_pkg::SLOT_W-1:0] : '0;
      ready_nonempty_o  <= (rlen_q != '0);
      ready_count_o     <= rl_ext[trwl_pkg::COUNT_W-1:0];
      wakeup_head_o     <= (wlen_q != '0) ? wh_ext[trwl_pkg::SLOT_W-1:0] : '0;
      wakeup_nonempty_o <= (wlen_q != '0);
      next_wakeup_o     <= nx_ext[trwl_pkg::SLOT_W-1:0];
      next_valid_o      <= nv_q;
      slot_state_o      <= have_slot ? st_q[s_q] : trwl_pkg::ST_UNUSED;
    end
  end

endmodule
`default_nettype wire
